// ===== src/cci_pkg.sv =====
// Shared types, constants and the chart table of the chart coefficient interpolator.
// Depends on nothing; every other source file imports it.
package cci_pkg;

    // Result codes carried in tuser.
    localparam logic [1:0] ERR_OK   = 2'd0;
    localparam logic [1:0] ERR_MACH = 2'd1;
    localparam logic [1:0] ERR_TEMP = 2'd2;

    // Chart span in Q16.16 raw units (0.05) and its rounding half.
    localparam int SPAN      = 3277;
    localparam int SPAN_HALF = 1638;
    localparam int STORED    = 21;
    // Reciprocals of SPAN: ceil(2^26 / SPAN) and ceil(2^30 / SPAN).
    localparam logic [47:0] RECIP_POS = 48'd20479;
    localparam logic [48:0] RECIP_Y   = 49'd327661;

    localparam logic [17:0] CHART_TAB [0:STORED-1] = '{
        18'd196608, 18'd180023, 18'd167522, 18'd156899, 18'd147350, 18'd138817,
        18'd130512, 18'd122879, 18'd115772, 18'd108953, 18'd102752, 18'd96883,
        18'd91431,  18'd86553,  18'd82019,  18'd77870,  18'd74307,  18'd71383,
        18'd69025,  18'd67155,  18'd65536
    };

    // Per-item control that rides along the divider cells.
    typedef struct packed {
        logic       valid;
        logic [1:0] err;
        logic       neg;
        logic       zero;
        logic       sat;
    } t_meta;

    // Data handed from one divider cell to the next.
    typedef struct packed {
        t_meta        meta;
        logic [61:0]  rem;
        logic [61:0]  den;
        logic [31:0]  quo;
    } t_div_bus;

    // Table read; indexes past the last stored point return that point.
    function automatic logic [17:0] chart_at(input logic [6:0] idx);
        logic [17:0] val;
        if (idx >= 7'(STORED)) begin
            val = CHART_TAB[STORED-1];
        end else begin
            val = CHART_TAB[idx[4:0]];
        end
        return val;
    endfunction

endpackage

// ===== src/cci_div_cell.sv =====
// One restoring division cell: doubles the partial remainder and settles one quotient bit.
// Depends on cci_pkg.
module cci_div_cell
    import cci_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  t_div_bus i_bus,
    output t_div_bus o_bus
);

    t_div_bus    r_bus;
    t_div_bus    n_bus;
    logic [62:0] r2;
    logic        ge;

    // Shift, compare and conditionally subtract the divisor.
    always_comb begin
        r2    = {i_bus.rem, 1'b0};
        ge    = r2 >= {1'b0, i_bus.den};
        n_bus = i_bus;
        if (ge) begin
            n_bus.rem = 62'(r2 - {1'b0, i_bus.den});
        end else begin
            n_bus.rem = r2[61:0];
        end
        n_bus.quo = {i_bus.quo[30:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus.meta.valid <= 1'b0;
        end else if (i_en) begin
            r_bus <= n_bus;
        end
    end

    assign o_bus = r_bus;

endmodule

// ===== src/cci_interp.sv =====
// Clamp and linear interpolation pipeline of the chart coefficient interpolator.
// Depends on cci_pkg.
module cci_interp
    import cci_pkg::*;
#(
    parameter int TABLE_POINTS = 21
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [1:0]  i_err,
    input  logic [31:0] i_coord,
    output logic        o_valid,
    output logic [1:0]  o_err,
    output logic [31:0] o_coord,
    output logic [17:0] o_coef
);

    localparam int POS_W = $clog2(SPAN * (TABLE_POINTS - 1) + 1);
    localparam int EST_W = $clog2(TABLE_POINTS + 1);
    localparam int SEG_W = $clog2(TABLE_POINTS);
    localparam int STAGES = 10;

    // Valid, code and coordinate travel alongside the arithmetic.
    logic [STAGES-1:0] r_vld;
    logic [1:0]        r_err   [0:STAGES-1];
    logic [31:0]       r_coord [0:STAGES-1];

    logic [POS_W-1:0]  r_pos1, r_pos2, r_pos3;
    logic [EST_W-1:0]  r_est2, r_est3;
    logic [31:0]       r_prod3;
    logic [SEG_W-1:0]  r_seg4;
    logic [11:0]       r_w4, r_w5;
    logic [17:0]       r_ya5, r_yb5;
    logic [29:0]       r_pa6, r_pb6;
    logic [29:0]       r_y7, r_y8, r_y9;
    logic [17:0]       r_est8, r_est9;
    logic [29:0]       r_prod9;
    logic [17:0]       r_coef;

    logic [11:0]       n_off;
    logic [47:0]       n_prod_pos;
    logic [32:0]       n_diff;
    logic [EST_W-1:0]  n_seg;
    logic [11:0]       n_w;
    logic [48:0]       n_prod_y;

    // Clamp the coordinate to the chart span and shift it to start at zero.
    always_comb begin
        if ($signed(i_coord) < -32'sd3277) begin
            n_off = 12'd0;
        end else if ($signed(i_coord) > 32'sd0) begin
            n_off = 12'(SPAN);
        end else begin
            n_off = 12'(i_coord + 32'(SPAN));
        end
    end

    assign n_prod_pos = 48'(r_pos1) * RECIP_POS;
    assign n_prod_y   = 49'(r_y7) * RECIP_Y;

    // Segment estimate is exact or one high; fix it and handle the top end.
    always_comb begin
        n_diff = 33'(r_pos3) - 33'(r_prod3);
        if (n_diff[32]) begin
            n_seg = r_est3 - EST_W'(1);
            n_w   = 12'(n_diff + 33'(SPAN));
        end else begin
            n_seg = r_est3;
            n_w   = n_diff[11:0];
        end
        if (32'(n_seg) >= 32'(TABLE_POINTS - 1)) begin
            n_seg = EST_W'(TABLE_POINTS - 2);
            n_w   = 12'(SPAN);
        end
    end

    // Control pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_err[0]   <= i_err;
            r_coord[0] <= i_coord;
            for (int i = 1; i < STAGES; i++) begin
                r_err[i]   <= r_err[i-1];
                r_coord[i] <= r_coord[i-1];
            end
        end
    end

    // Arithmetic stages.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pos1  <= POS_W'(32'(n_off) * 32'(TABLE_POINTS - 1));
            r_est2  <= n_prod_pos[26 +: EST_W];
            r_pos2  <= r_pos1;
            r_prod3 <= 32'(r_est2) * 32'(SPAN);
            r_est3  <= r_est2;
            r_pos3  <= r_pos2;
            r_seg4  <= SEG_W'(n_seg);
            r_w4    <= n_w;
            r_ya5   <= chart_at(7'(r_seg4));
            r_yb5   <= chart_at(7'(r_seg4) + 7'd1);
            r_w5    <= r_w4;
            r_pa6   <= 30'(r_ya5) * 30'(12'(SPAN) - r_w5);
            r_pb6   <= 30'(r_yb5) * 30'(r_w5);
            r_y7    <= r_pa6 + r_pb6 + 30'(SPAN_HALF);
            r_est8  <= n_prod_y[30 +: 18];
            r_y8    <= r_y7;
            r_prod9 <= 30'(r_est8) * 30'(SPAN);
            r_est9  <= r_est8;
            r_y9    <= r_y8;
            if (r_err[STAGES-2] != ERR_OK) begin
                r_coef <= 18'd0;
            end else if (r_prod9 > r_y9) begin
                r_coef <= r_est9 - 18'd1;
            end else begin
                r_coef <= r_est9;
            end
        end
    end

    assign o_valid = r_vld[STAGES-1];
    assign o_err   = r_err[STAGES-1];
    assign o_coord = r_coord[STAGES-1];
    assign o_coef  = r_coef;

endmodule

// ===== src/chart_coefficient_interpolator.sv =====
// Chart coefficient interpolator: one request per cycle through a pipeline of two
// setup stages, 32 division cells with one quotient bit each, one saturation stage
// and ten clamp and interpolation stages, the last one the output register.
// The whole pipeline stalls while a finished result is not taken.
// Reset is synchronous and active low and clears every valid bit.
module chart_coefficient_interpolator
    import cci_pkg::*;
#(
    parameter int TABLE_POINTS = 21
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // Fields from bit 0: mach_value[31:0], temp_ratio[31:0].
    input  logic [63:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // Fields from bit 0: coefficient[17:0], chart_coordinate[31:0], zero fill.
    output logic [55:0] o_m_tdata,
    // Fields from bit 0: error_code[1:0].
    output logic [1:0]  o_m_tuser
);

    localparam int CELLS = 32;

    logic        adv;
    logic        s_take;

    // Setup stages.
    t_meta       r_meta1, r_meta2;
    logic [30:0] r_m1, r_mag1, r_mag2;
    logic [61:0] r_den2;
    t_meta       n_meta1;
    logic [30:0] n_mag1;
    logic [30:0] t_raw;
    logic [61:0] n_num_sh;

    t_div_bus    bus [0:CELLS];

    // Coordinate stage.
    logic        r_cvld;
    logic [1:0]  r_cerr;
    logic [31:0] r_coord;
    logic [31:0] n_coord;
    t_meta       fm;
    logic [31:0] fq;

    logic        i_vld_out;
    logic [1:0]  err_out;
    logic [31:0] coord_out;
    logic [17:0] coef_out;

    assign adv        = !i_vld_out || i_m_tready;
    assign o_s_tready = adv;
    assign s_take     = i_s_tvalid && adv;

    // Screen the arguments and form the numerator magnitude.
    always_comb begin
        t_raw         = i_s_tdata[62:32];
        n_meta1.valid = s_take;
        n_meta1.sat   = 1'b0;
        if (i_s_tdata[31]) begin
            n_meta1.err = ERR_MACH;
        end else if (i_s_tdata[63]) begin
            n_meta1.err = ERR_TEMP;
        end else begin
            n_meta1.err = ERR_OK;
        end
        n_meta1.neg  = t_raw < 31'd65536;
        n_meta1.zero = t_raw == 31'd65536;
        if (n_meta1.neg) begin
            n_mag1 = 31'd65536 - t_raw;
        end else begin
            n_mag1 = t_raw - 31'd65536;
        end
    end

    assign n_num_sh = 62'({r_mag2, 16'h0000});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meta1.valid <= 1'b0;
            r_meta2.valid <= 1'b0;
        end else if (adv) begin
            r_meta1 <= n_meta1;
            r_meta2 <= r_meta1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m1   <= i_s_tdata[30:0];
            r_mag1 <= n_mag1;
            r_den2 <= 62'(r_m1) * 62'(r_m1);
            r_mag2 <= r_mag1;
        end
    end

    // Quotient of more than 32 bits (or a zero divisor) saturates at once.
    always_comb begin
        bus[0].meta     = r_meta2;
        bus[0].meta.sat = n_num_sh >= r_den2;
        bus[0].rem      = (n_num_sh >= r_den2) ? 62'd0 : n_num_sh;
        bus[0].den      = r_den2;
        bus[0].quo      = 32'd0;
    end

    // Chain of division cells.
    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        cci_div_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (adv),
            .i_bus  (bus[g]),
            .o_bus  (bus[g+1])
        );
    end

    // Apply the sign and saturate to Q16.16.
    always_comb begin
        fm = bus[CELLS].meta;
        fq = bus[CELLS].quo;
        if (fm.err != ERR_OK || fm.zero) begin
            n_coord = 32'd0;
        end else if (fm.sat) begin
            n_coord = fm.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else if (!fm.neg) begin
            n_coord = fq[31] ? 32'h7FFF_FFFF : fq;
        end else begin
            n_coord = (fq[31] && (fq[30:0] != 31'd0)) ? 32'h8000_0000 : (32'd0 - fq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvld <= 1'b0;
        end else if (adv) begin
            r_cvld <= fm.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cerr  <= fm.err;
            r_coord <= n_coord;
        end
    end

    cci_interp #(
        .TABLE_POINTS(TABLE_POINTS)
    ) u_interp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (adv),
        .i_valid(r_cvld),
        .i_err  (r_cerr),
        .i_coord(r_coord),
        .o_valid(i_vld_out),
        .o_err  (err_out),
        .o_coord(coord_out),
        .o_coef (coef_out)
    );

    assign o_m_tvalid = i_vld_out;
    assign o_m_tdata  = {6'd0, coord_out, coef_out};
    assign o_m_tuser  = err_out;

    // A rejected request delivers zero coefficient and zero coordinate.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != ERR_OK) |-> (o_m_tdata[49:0] == 50'd0))
        else $error("error result carries nonzero data");

    // The coefficient never exceeds the top of the chart and the fill bits stay zero.
    a_coef_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[17:0] <= 18'd196608 && o_m_tdata[55:50] == 6'd0))
        else $error("coefficient out of range");

    // A request taken while stalled output is pending would be lost.
    a_no_take_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |-> !o_s_tready)
        else $error("input accepted during output stall");

    // The pipeline holds its output while stalled.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the chart coefficient interpolator stream block.
// Depends on cci_pkg and chart_coefficient_interpolator; a built-in predictor checks results.
`timescale 1ns / 1ps

module testbench;
    import cci_pkg::*;

    typedef struct packed {
        logic [31:0] temp;
        logic [31:0] mach;
    } t_request;

    typedef struct {
        logic [17:0] coef;
        logic [31:0] coord;
        logic [1:0]  err;
    } t_chart_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [63:0] i_s_tdata;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [55:0] o_m_tdata;
    logic [1:0]  o_m_tuser;

    t_request      pending_requests[$];
    t_chart_result expected_results[$];
    int            mismatches;
    int            cycle_count;
    bit            request_taken;
    bit            hold_off;

    chart_coefficient_interpolator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // Clock with a 10 ns period.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Coordinate (ratio - 1) / mach^2, saturated to Q16.16.
    function automatic logic [31:0] chart_coordinate(input logic [31:0] mach,
                                                     input logic [31:0] temp);
        longint          num;
        longint unsigned mag;
        logic [127:0]    den;
        logic [127:0]    quot;
        logic [31:0]     x;
        num = longint'($signed(temp)) - 65536;
        mag = (num < 0) ? longint'(-num) : longint'(num);
        den = 128'(mach) * 128'(mach);
        if (num == 0) begin
            x = 32'd0;
        end else if (den == 0) begin
            x = (num > 0) ? 32'h7fffffff : 32'h80000000;
        end else begin
            quot = (128'(mag) << 48) / den;
            if (num > 0) begin
                x = (quot > 128'd2147483647) ? 32'h7fffffff : quot[31:0];
            end else begin
                x = (quot > 128'd2147483648) ? 32'h80000000 : 32'(-quot[31:0]);
            end
        end
        return x;
    endfunction

    // Clamp to the chart span and interpolate the table linearly.
    function automatic logic [17:0] chart_lookup(input logic [31:0] x);
        longint xc;
        longint pos;
        longint seg;
        longint w;
        longint y;
        xc = longint'($signed(x));
        if (xc < -SPAN) xc = -SPAN;
        if (xc > 0) xc = 0;
        pos = (xc + SPAN) * 20;
        seg = pos / SPAN;
        w   = pos % SPAN;
        if (seg >= 20) begin
            seg = 19;
            w   = SPAN;
        end
        y = longint'(CHART_TAB[seg]) * (SPAN - w) + longint'(CHART_TAB[seg + 1]) * w
            + SPAN_HALF;
        return 18'(y / SPAN);
    endfunction

    function automatic t_chart_result predict_chart(input t_request req);
        t_chart_result r;
        r.coef  = '0;
        r.coord = '0;
        if (req.mach[31]) begin
            r.err = ERR_MACH;
        end else if (req.temp[31]) begin
            r.err = ERR_TEMP;
        end else begin
            r.err   = ERR_OK;
            r.coord = chart_coordinate(req.mach, req.temp);
            r.coef  = chart_lookup(r.coord);
        end
        return r;
    endfunction

    function automatic t_request mk(input logic [31:0] mach, input logic [31:0] temp);
        t_request r;
        r.mach = mach;
        r.temp = temp;
        return r;
    endfunction

    // Random request: mostly valid operands landing in or near the chart span.
    function automatic t_request random_request();
        t_request r;
        int       kind;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1: begin
                r.mach = $urandom;
                r.temp = $urandom;
            end
            2: begin
                r.mach = $urandom_range(0, 255);
                r.temp = $urandom_range(0, 32'h7fffffff);
            end
            3: begin
                r.mach = $urandom_range(0, 32'h7fffffff);
                r.temp = 32'd65536 + $urandom_range(0, 8) - 4;
            end
            default: begin
                r.mach = $urandom_range(32'h4000, 32'h60000);
                r.temp = 32'd65536 - $urandom_range(0, 20000) + $urandom_range(0, 200);
            end
        endcase
        return r;
    endfunction

    // Cycle counter and reset.
    initial begin
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Record accepted requests and queue their predicted results.
    always @(posedge i_clk) begin
        request_taken <= 1'b0;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            expected_results.push_back(predict_chart(t_request'(i_s_tdata)));
            request_taken <= 1'b1;
        end
    end

    // Request driver: a held request stays until it is taken.
    always @(negedge i_clk) begin
        bit idle;
        idle = ($urandom_range(0, 99) < 8) && !(cycle_count > 700 && cycle_count < 1300);
        if (request_taken) begin
            void'(pending_requests.pop_front());
        end
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (i_s_tvalid && !request_taken) begin
            i_s_tvalid <= 1'b1;
        end else if (pending_requests.size() > (request_taken ? 1 : 0) - 0 && !idle
                     && pending_requests.size() > 0) begin
            i_s_tvalid <= 1'b1;
            i_s_tdata  <= pending_requests[0];
        end else begin
            i_s_tvalid <= 1'b0;
        end
    end

    // Result receiver with random stalls and one long hold-off.
    always @(negedge i_clk) begin
        bit idle;
        idle = ($urandom_range(0, 99) < 8) && !(cycle_count > 700 && cycle_count < 1300);
        i_m_tready <= !hold_off && !idle;
    end

    initial begin
        hold_off = 1'b0;
        wait (cycle_count == 400);
        hold_off = 1'b1;
        repeat (300) @(negedge i_clk);
        hold_off = 1'b0;
    end

    // Result monitor.
    always @(posedge i_clk) begin
        t_chart_result exp_r;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_results.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10) $display("unexpected result tdata=%h", o_m_tdata);
            end else begin
                exp_r = expected_results.pop_front();
                if (o_m_tdata[17:0] !== exp_r.coef || o_m_tdata[49:18] !== exp_r.coord
                    || o_m_tdata[55:50] !== 6'd0 || o_m_tuser !== exp_r.err) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10) begin
                        $display({"mismatch: exp coef=%0d coord=%h err=%0d ",
                                  "got coef=%0d coord=%h err=%0d"},
                                 exp_r.coef, exp_r.coord, exp_r.err, o_m_tdata[17:0],
                                 o_m_tdata[49:18], o_m_tuser);
                    end
                end
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        mismatches  = 0;
        cycle_count = 0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_m_tready  = 1'b0;
        request_taken = 1'b0;
        // Error codes, zero mach, saturation, span ends and the top segment.
        pending_requests.push_back(mk(32'hffffffff, 32'd65536));
        pending_requests.push_back(mk(32'h80000000, 32'h80000000));
        pending_requests.push_back(mk(32'd65536, 32'hffffffff));
        pending_requests.push_back(mk(32'd0, 32'd100000));
        pending_requests.push_back(mk(32'd0, 32'd100));
        pending_requests.push_back(mk(32'd0, 32'd65536));
        pending_requests.push_back(mk(32'h7fffffff, 32'h7fffffff));
        pending_requests.push_back(mk(32'd1, 32'd0));
        pending_requests.push_back(mk(32'd1, 32'h7fffffff));
        pending_requests.push_back(mk(32'h7fffffff, 32'd0));
        pending_requests.push_back(mk(32'd65536, 32'd0));
        pending_requests.push_back(mk(32'd65536, 32'd65536 - 3277));
        pending_requests.push_back(mk(32'd65536, 32'd65536 - 3278));
        pending_requests.push_back(mk(32'd65536, 32'd65536 - 1638));
        pending_requests.push_back(mk(32'd65536, 32'd65536 - 1));
        pending_requests.push_back(mk(32'd65536, 32'd65541));
        pending_requests.push_back(mk(32'd131072, 32'd60000));
        pending_requests.push_back(mk(32'd256, 32'd65535));
        pending_requests.push_back(mk(32'd181, 32'd0));
        wait (i_rst_n);
        // Sender pause until the pipeline drains.
        wait (pending_requests.size() == 0 && expected_results.size() == 0);
        repeat (1430) pending_requests.push_back(random_request());
        wait (pending_requests.size() == 0 && expected_results.size() == 0);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Timeout.
    initial begin
        #2ms;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== chart_coefficient_interpolator.f =====
src/cci_pkg.sv
src/cci_div_cell.sv
src/cci_interp.sv
src/chart_coefficient_interpolator.sv
dv/testbench.sv
